/* rtl/core/rmts_pkg.sv */
`timescale 1ns / 1ps
package rmts_pkg;

	// Slot store and configuration field sizes
	localparam int MAX_SLOTS = 4;
	localparam int SLOT_FW   = 2;
	localparam int CFG_W     = 16;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 5;
	localparam int REG_IDX_W = 3;
	localparam int SEG_W     = 32;

	// Priority compare runs one bit wider so "no candidate" sits above every period
	localparam int PRIO_W = CFG_W + 1;
	localparam logic [PRIO_W-1:0] NO_PRIORITY = {1'b1, {CFG_W{1'b0}}};

	// Low bit of the register index selects burst or period
	localparam logic REG_KIND_BURST  = 1'b0;
	localparam logic REG_KIND_PERIOD = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic               scan_init;
		logic               scan;
		logic [SLOT_FW-1:0] slot;
		logic               commit_tick;
		logic               commit_end;
	} cmd_t;

endpackage

/* rtl/core/rmts_regs.sv */
`timescale 1ns / 1ps
module rmts_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rmts_pkg::APB_AW-1:0]   paddr,
	input  logic [rmts_pkg::APB_DW-1:0]   pwdata,
	output logic [rmts_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output logic [rmts_pkg::CFG_W-1:0]    burst [rmts_pkg::MAX_SLOTS],
	output logic [rmts_pkg::CFG_W-1:0]    period [rmts_pkg::MAX_SLOTS]
);
	import rmts_pkg::*;

	logic [CFG_W-1:0]     burst_q [MAX_SLOTS];
	logic [CFG_W-1:0]     period_q [MAX_SLOTS];
	logic [REG_IDX_W-1:0] reg_idx;
	logic [SLOT_FW-1:0]   reg_slot;
	logic                 wr_en;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[APB_AW-1:2];
	assign reg_slot = reg_idx[REG_IDX_W-1:1];
	assign wr_en    = psel & penable & pwrite;

	// Store burst and period words, even for slots the scheduler leaves unused
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				burst_q[i]  <= '0;
				period_q[i] <= '0;
			end
		end else if (wr_en) begin
			if (reg_idx[0] == REG_KIND_PERIOD) begin
				period_q[reg_slot] <= pwdata[CFG_W-1:0];
			end else begin
				burst_q[reg_slot] <= pwdata[CFG_W-1:0];
			end
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx[0])
			REG_KIND_BURST:  prdata = {{(APB_DW-CFG_W){1'b0}}, burst_q[reg_slot]};
			REG_KIND_PERIOD: prdata = {{(APB_DW-CFG_W){1'b0}}, period_q[reg_slot]};
			default:         prdata = '0;
		endcase
	end

	assign burst  = burst_q;
	assign period = period_q;

endmodule

/* rtl/core/rmts_ctrl.sv */
`timescale 1ns / 1ps
module rmts_ctrl #(
	parameter int TASK_SLOTS = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            end_run,
	output logic            out_valid,
	input  logic            out_stall,
	output rmts_pkg::cmd_t  cmd
);
	import rmts_pkg::*;

	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [SLOT_W-1:0] cnt_q;
	logic              end_q;
	logic              out_valid_q;
	logic              accept;
	logic              can_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid & ~in_stall;
	assign can_load  = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;

	// Sequencer: accept, step through the slots (skipped for an end-of-run word), then commit into the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the result word on commit, drop it once taken
			if (state_q == ST_FIN && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						end_q   <= end_run;
						cnt_q   <= '0;
						state_q <= end_run ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + SLOT_W'(1);
					if (cnt_q == LAST_SLOT) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Drive datapath commands
	always_comb begin
		cmd             = '0;
		cmd.scan_init   = accept;
		cmd.scan        = (state_q == ST_SCAN);
		cmd.slot        = SLOT_FW'(cnt_q);
		cmd.commit_tick = (state_q == ST_FIN) && can_load && !end_q;
		cmd.commit_end  = (state_q == ST_FIN) && can_load && end_q;
	end

	a_tick_scans: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !end_run |=> state_q == ST_SCAN)
		else $error("tick word did not enter the slot scan");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q <= LAST_SLOT)
		else $error("slot counter beyond last slot");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result word raised outside commit");

endmodule

/* rtl/core/rmts_dp.sv */
`timescale 1ns / 1ps
module rmts_dp #(
	parameter int TASK_SLOTS = 4,
	parameter int TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rmts_pkg::cmd_t                cmd,
	input  logic [rmts_pkg::CFG_W-1:0]    burst [rmts_pkg::MAX_SLOTS],
	input  logic [rmts_pkg::CFG_W-1:0]    period [rmts_pkg::MAX_SLOTS],
	output logic [rmts_pkg::SLOT_FW-1:0]  running_slot,
	output logic                          running_idle,
	output logic                          segment_done,
	output logic [rmts_pkg::SLOT_FW-1:0]  segment_slot,
	output logic                          segment_was_idle,
	output logic [rmts_pkg::SEG_W-1:0]    segment_start,
	output logic [rmts_pkg::SEG_W-1:0]    segment_end
);
	import rmts_pkg::*;

	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	logic [TIME_WIDTH-1:0] time_q;
	logic [TIME_WIDTH-1:0] seg_start_q;
	logic                  last_idle_q;
	logic [SLOT_FW-1:0]    last_slot_q;
	logic [CFG_W-1:0]      rem_q [TASK_SLOTS];
	logic [TIME_WIDTH-1:0] next_q [TASK_SLOTS];
	logic [PRIO_W-1:0]     best_q;
	logic                  cand_idle_q;
	logic [SLOT_FW-1:0]    cand_slot_q;

	logic [SLOT_W-1:0]     idx;
	logic [SLOT_W-1:0]     cand_idx;
	logic [CFG_W-1:0]      cur_period;
	logic [CFG_W-1:0]      cur_burst;
	logic                  release_hit;
	logic [CFG_W-1:0]      rem_eff;
	logic                  wins;
	logic                  sel_change;
	logic                  close_seg;

	// Release check and priority compare for the slot under scan
	assign idx         = cmd.slot[SLOT_W-1:0];
	assign cand_idx    = cand_slot_q[SLOT_W-1:0];
	assign cur_period  = period[cmd.slot];
	assign cur_burst   = burst[cmd.slot];
	assign release_hit = (cur_period != '0) && (time_q == next_q[idx]);
	assign rem_eff     = release_hit ? cur_burst : rem_q[idx];
	assign wins        = (cur_period != '0) && (rem_eff != '0) && ({1'b0, cur_period} < best_q);

	// A change of selection closes a segment except at time zero
	assign sel_change  = (cand_idle_q != last_idle_q) ||
	                     (!cand_idle_q && (cand_slot_q != last_slot_q));
	assign close_seg   = (time_q != '0) && sel_change;

	// Per-slot state: release, then take one tick from the winner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				rem_q[i]  <= '0;
				next_q[i] <= '0;
			end
		end else if (cmd.scan) begin
			if (release_hit) begin
				rem_q[idx]  <= cur_burst;
				next_q[idx] <= next_q[idx] + TIME_WIDTH'(cur_period);
			end
		end else if (cmd.commit_tick && !cand_idle_q) begin
			rem_q[cand_idx] <= rem_q[cand_idx] - CFG_W'(1);
		end
	end

	// Running best candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= NO_PRIORITY;
			cand_idle_q <= 1'b1;
			cand_slot_q <= '0;
		end else if (cmd.scan_init) begin
			best_q      <= NO_PRIORITY;
			cand_idle_q <= 1'b1;
			cand_slot_q <= '0;
		end else if (cmd.scan && wins) begin
			best_q      <= {1'b0, cur_period};
			cand_idle_q <= 1'b0;
			cand_slot_q <= cmd.slot;
		end
	end

	// Time, open segment and last selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q      <= '0;
			seg_start_q <= '0;
			last_idle_q <= 1'b1;
			last_slot_q <= '0;
		end else if (cmd.commit_tick) begin
			time_q      <= time_q + TIME_WIDTH'(1);
			last_idle_q <= cand_idle_q;
			last_slot_q <= cand_slot_q;
			if (close_seg) begin
				seg_start_q <= time_q;
			end
		end
	end

	// Low word of the times for the segment report
	logic [SEG_W-1:0] time_lo;
	logic [SEG_W-1:0] seg_start_lo;
	if (TIME_WIDTH >= SEG_W) begin : g_wide_time
		assign time_lo      = time_q[SEG_W-1:0];
		assign seg_start_lo = seg_start_q[SEG_W-1:0];
	end else begin : g_narrow_time
		assign time_lo      = {{(SEG_W-TIME_WIDTH){1'b0}}, time_q};
		assign seg_start_lo = {{(SEG_W-TIME_WIDTH){1'b0}}, seg_start_q};
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (cmd.commit_tick) begin
			running_slot     <= cand_idle_q ? '0 : cand_slot_q;
			running_idle     <= cand_idle_q;
			segment_done     <= close_seg;
			segment_slot     <= (close_seg && !last_idle_q) ? last_slot_q : '0;
			segment_was_idle <= close_seg && last_idle_q;
			segment_start    <= close_seg ? seg_start_lo : '0;
			segment_end      <= close_seg ? time_lo : '0;
		end else if (cmd.commit_end) begin
			running_slot     <= '0;
			running_idle     <= 1'b1;
			segment_done     <= 1'b1;
			segment_slot     <= last_idle_q ? '0 : last_slot_q;
			segment_was_idle <= last_idle_q;
			segment_start    <= seg_start_lo;
			segment_end      <= time_lo;
		end
	end

	a_time_advance: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_tick |=> time_q == $past(time_q) + TIME_WIDTH'(1))
		else $error("time did not advance on a tick");

	a_end_keeps_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_end |=> $stable(time_q) && $stable(seg_start_q))
		else $error("end of run altered scheduler state");

endmodule

/* rtl/core/rate_monotonic_tick_scheduler.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Word
// in        sink       in_valid / in_stall   end_run
// out       source     out_valid / out_stall running_slot .. segment_end
// cfg       APB slave  psel/penable/pready   burst and period per slot
//
// A tick word is accepted, then each slot passes in turn through the shared
// release-and-compare unit, and the word is committed. An end-of-run word is
// committed straight after acceptance. Only one word is in flight at a time.
// Reset clears all slot state, the time counter and the configuration.
// A result held under out_stall stalls the commit, not the acceptance of the next word.
module rate_monotonic_tick_scheduler #(
	parameter int TASK_SLOTS = 4,
	parameter int TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          end_run,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rmts_pkg::SLOT_FW-1:0]  running_slot,
	output logic                          running_idle,
	output logic                          segment_done,
	output logic [rmts_pkg::SLOT_FW-1:0]  segment_slot,
	output logic                          segment_was_idle,
	output logic [rmts_pkg::SEG_W-1:0]    segment_start,
	output logic [rmts_pkg::SEG_W-1:0]    segment_end,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rmts_pkg::APB_AW-1:0]   paddr,
	input  logic [rmts_pkg::APB_DW-1:0]   pwdata,
	output logic [rmts_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import rmts_pkg::*;

	cmd_t             cmd;
	logic [CFG_W-1:0] burst [MAX_SLOTS];
	logic [CFG_W-1:0] period [MAX_SLOTS];

	rmts_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.burst   (burst),
		.period  (period)
	);

	rmts_ctrl #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.end_run   (end_run),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	rmts_dp #(
		.TASK_SLOTS (TASK_SLOTS),
		.TIME_WIDTH (TIME_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.burst            (burst),
		.period           (period),
		.running_slot     (running_slot),
		.running_idle     (running_idle),
		.segment_done     (segment_done),
		.segment_slot     (segment_slot),
		.segment_was_idle (segment_was_idle),
		.segment_start    (segment_start),
		.segment_end      (segment_end)
	);

endmodule
